[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the matcher RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every edge outside reset.
`define EMSM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that cond is never true outside reset.
`define EMSM_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define EMSM_ASSERT(name, clk, rst_n, prop, msg)
`define EMSM_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

[rtl/emsm_pkg.sv]
// ---------------------------------------------------------------------------
// emsm_pkg
// Types and codes of the event mask subscription matcher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package emsm_pkg;

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_SEND       = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_SUBSET   = 2'd0,
    MODE_ALL_BITS = 2'd1
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  // Table read: none, newest entry, next older entry, next newer entry.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_TOP,
    RD_DOWN,
    RD_UP
  } rd_sel_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  task_id;
    logic [31:0] event_mask;
    logic [1:0]  match_mode;
  } emsm_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired;
    logic [7:0] fired_task;
    logic       last;
  } emsm_out_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] mask;
    logic [1:0]  mode;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic       load_item;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       wr_front;
    logic       wr_shift;
    rd_sel_e    rd_sel;
    logic       pend_take;
    logic       emit_pend;
    logic       emit_final;
    logic       status_load;
    logic [1:0] status_val;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       cnt_zero;
    logic       cnt_full;
    logic       ptr_zero;
    logic       ptr_top;
    logic       hit_task;
    logic       hit_event;
    logic       pend;
    logic       out_free;
  } dp_sts_t;

endpackage

[rtl/emsm_ram.sv]
// ---------------------------------------------------------------------------
// emsm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module emsm_ram #(
  parameter int DataW = 42,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/emsm_ctrl.sv]
// ---------------------------------------------------------------------------
// emsm_ctrl
// Sequencer: decodes an item and steps the datapath through scan and shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module emsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  emsm_pkg::dp_sts_t sts_i,
  output emsm_pkg::dp_cmd_t cmd_o
);
  import emsm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.command)
          CMD_UNREGISTER, CMD_SEND: state_d = sts_i.cnt_zero ? S_FINISH : S_SCAN;
          default:                  state_d = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (sts_i.command == CMD_UNREGISTER) begin
          priority if (sts_i.hit_task) begin
            state_d = sts_i.ptr_top ? S_FINISH : S_SHIFT;
          end else if (sts_i.ptr_zero) begin
            state_d = S_FINISH;
          end else begin
            state_d = state_q;
          end
        end else if (!(sts_i.hit_event && sts_i.pend && !sts_i.out_free)) begin
          if (sts_i.ptr_zero) begin
            state_d = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        if (sts_i.ptr_top) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      S_DISPATCH: begin
        unique case (sts_i.command)
          CMD_REGISTER: begin
            if (sts_i.cnt_full) begin
              cmd_o.status_load = 1'b1;
              cmd_o.status_val  = ST_FULL;
            end else begin
              cmd_o.wr_front = 1'b1;
              cmd_o.cnt_inc  = 1'b1;
            end
          end
          CMD_UNREGISTER: begin
            if (sts_i.cnt_zero) begin
              cmd_o.status_load = 1'b1;
              cmd_o.status_val  = ST_NOT_FOUND;
            end else begin
              cmd_o.rd_sel = RD_TOP;
            end
          end
          CMD_SEND: begin
            if (!sts_i.cnt_zero) begin
              cmd_o.rd_sel = RD_TOP;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (sts_i.command == CMD_UNREGISTER) begin
          priority if (sts_i.hit_task) begin
            if (sts_i.ptr_top) begin
              cmd_o.cnt_dec = 1'b1;
            end else begin
              cmd_o.rd_sel = RD_UP;
            end
          end else if (sts_i.ptr_zero) begin
            cmd_o.status_load = 1'b1;
            cmd_o.status_val  = ST_NOT_FOUND;
          end else begin
            cmd_o.rd_sel = RD_DOWN;
          end
        end else if (!(sts_i.hit_event && sts_i.pend && !sts_i.out_free)) begin
          // Hold a hit back until the next one shows it was not the final one.
          cmd_o.pend_take = sts_i.hit_event;
          cmd_o.emit_pend = sts_i.hit_event && sts_i.pend;
          if (!sts_i.ptr_zero) begin
            cmd_o.rd_sel = RD_DOWN;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.wr_shift = 1'b1;
        if (sts_i.ptr_top) begin
          cmd_o.cnt_dec = 1'b1;
        end else begin
          cmd_o.rd_sel = RD_UP;
        end
      end
      S_FINISH: begin
        cmd_o.emit_final = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

[rtl/emsm_dpath.sv]
// ---------------------------------------------------------------------------
// emsm_dpath
// Subscription table, fill count, scan pointer, match logic and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module emsm_dpath #(
  parameter int TableDepth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  emsm_pkg::emsm_in_t  in_data_i,
  input  emsm_pkg::dp_cmd_t   cmd_i,
  output emsm_pkg::dp_sts_t   sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output emsm_pkg::emsm_out_t out_data_o
);
  import emsm_pkg::*;

  localparam int CntW  = $clog2(TableDepth + 1);
  localparam int AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  // Entries sit oldest at address 0, newest at count - 1.
  emsm_in_t         item_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic [7:0]       pend_task_q;
  logic [1:0]       status_q;
  emsm_out_t        res_q, res_d;
  logic             res_vld_q, res_vld_d;

  logic [CntW-1:0]   count_m1;
  logic [AddrW-1:0]  top_addr;
  logic              rd_en;
  logic [AddrW-1:0]  raddr;
  logic              wr_en;
  logic [AddrW-1:0]  waddr;
  logic [EntryW-1:0] wdata;
  logic [EntryW-1:0] rdata;
  entry_t            rd_entry;
  entry_t            new_entry;
  logic              hit_event;
  logic              out_free;
  logic              res_load;

  assign count_m1 = count_q - CntW'(1);
  assign top_addr = count_m1[AddrW-1:0];

  always_comb begin
    raddr = ptr_q;
    unique case (cmd_i.rd_sel)
      RD_TOP:  raddr = top_addr;
      RD_DOWN: raddr = ptr_q - AddrW'(1);
      RD_UP:   raddr = ptr_q + AddrW'(1);
      default: raddr = ptr_q;
    endcase
  end

  assign rd_en = (cmd_i.rd_sel != RD_NONE);
  assign ptr_d = rd_en ? raddr : ptr_q;

  assign new_entry = '{task_id: item_q.task_id, mask: item_q.event_mask,
                       mode: item_q.match_mode};

  assign wr_en = cmd_i.wr_front || cmd_i.wr_shift;
  assign waddr = cmd_i.wr_front ? count_q[AddrW-1:0] : ptr_q - AddrW'(1);
  assign wdata = cmd_i.wr_front ? new_entry : rdata;

  emsm_ram #(
    .DataW(EntryW),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_entry = entry_t'(rdata);

  always_comb begin
    unique case (rd_entry.mode)
      MODE_SUBSET:   hit_event = ((rd_entry.mask | item_q.event_mask) == rd_entry.mask);
      MODE_ALL_BITS: hit_event = ((rd_entry.mask & item_q.event_mask) == rd_entry.mask);
      default:       hit_event = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_m1;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (cmd_i.load_item) begin
      pend_d = 1'b0;
    end else if (cmd_i.pend_take) begin
      pend_d = 1'b1;
    end
  end

  // Result register: load a mid-stream hit or the closing result.
  assign out_free = !res_vld_q || !out_stall_i;
  assign res_load = cmd_i.emit_pend || cmd_i.emit_final;

  always_comb begin
    res_d = res_q;
    if (cmd_i.emit_pend) begin
      res_d = '{status: ST_OK, fired: 1'b1, fired_task: pend_task_q, last: 1'b0};
    end else if (cmd_i.emit_final) begin
      res_d = '{status: status_q, fired: pend_q,
                fired_task: pend_q ? pend_task_q : 8'd0, last: 1'b1};
    end
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (res_load) begin
      res_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.pend_take) begin
      pend_task_q <= rd_entry.task_id;
    end
    if (cmd_i.load_item) begin
      status_q <= ST_OK;
    end else if (cmd_i.status_load) begin
      status_q <= cmd_i.status_val;
    end
    res_q <= res_d;
  end

  assign sts_o = '{
    command:   item_q.command,
    cnt_zero:  (count_q == '0),
    cnt_full:  (count_q == CntW'(TableDepth)),
    ptr_zero:  (ptr_q == '0),
    ptr_top:   (CntW'(ptr_q) == count_m1),
    hit_task:  (rd_entry.task_id == item_q.task_id),
    hit_event: hit_event,
    pend:      pend_q,
    out_free:  out_free
  };

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  `EMSM_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CntW'(TableDepth), "fill count overflow")
  `EMSM_ASSERT_NEVER(a_no_result_overwrite, clk_i, rst_ni, res_load && res_vld_q && out_stall_i, "result overwritten while stalled")
  `EMSM_ASSERT_NEVER(a_no_insert_when_full, clk_i, rst_ni, cmd_i.wr_front && (count_q == CntW'(TableDepth)), "insert into full table")

endmodule

[rtl/event_mask_subscription_matcher_core.sv]
// Register and unused commands go from dispatch straight to their result. Unregister
// scans the table from the newest entry down for the task, then shifts the entries
// above it down one place. Send scans all stored entries, one entry per cycle through the
// table RAM read port; a stalled output holds the scan. Items are taken one at a time.
// Reset empties the table at once by clearing the fill count; there is no clearing pass.
// ---------------------------------------------------------------------------
// event_mask_subscription_matcher_core
// Subscription table with register, unregister and event send commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module event_mask_subscription_matcher_core #(
  parameter int TableDepth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  emsm_pkg::emsm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output emsm_pkg::emsm_out_t out_data_o
);
  import emsm_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  emsm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (dp_sts),
    .cmd_o     (dp_cmd)
  );

  emsm_dpath #(
    .TableDepth(TableDepth)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule
